### rtl/stp_pkg.sv
// types and codes shared by the software timer pool
// no dependencies
package stp_pkg;
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [2:0] KIND_ALLOCATED = 3'd0;
  localparam logic [2:0] KIND_FULL      = 3'd1;
  localparam logic [2:0] KIND_FREED     = 3'd2;
  localparam logic [2:0] KIND_BAD       = 3'd3;
  localparam logic [2:0] KIND_FIRED     = 3'd4;

  localparam int MAX_RESULTS = 16;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  slot;
    logic [31:0] period;
    logic [31:0] start_elapsed;
    logic        start_active;
    logic        repeat_req;
    logic [15:0] delta;
  } stp_in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] slot_out;
    logic       last;
  } stp_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ALLOC_WR, ST_FREE_RD, ST_FREE_NX, ST_FREE_PV, ST_TICK
  } stp_state_t;
endpackage

### rtl/software_timer_pool_unit.sv
// software timer pool top level: linked list of timers held in one slot memory
// depends on stp_pkg
// allocate: word in the cycle after accept, then busy in ST_ALLOC_WR to link the old
// tail if the list was not empty; free: bad handle word in the cycle after accept; else
// ST_FREE_RD, ST_FREE_NX and ST_FREE_PV unlink the entry and the word is registered
// from ST_FREE_PV; tick: one listed timer per cycle, each fire word leaves once the next
// fire or the list end is seen; one command at a time
// rst clears the allocation and active flags and empties the list; memory needs no clearing
module software_timer_pool_unit
  import stp_pkg::*;
#(
  parameter int TIMERS    = 16,
  parameter int TIME_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  stp_in_t  cmd_in,
  output logic     done,
  output stp_out_t result
);
  localparam int SW = $clog2(TIMERS);
  localparam int LW = SW + 1;
  localparam logic [LW-1:0] NIL = LW'(TIMERS);
  localparam logic [TIME_BITS-1:0] TMAX = '1;
  localparam int CW = $clog2(MAX_RESULTS + 1);
  localparam int DW = (TIME_BITS > 16) ? TIME_BITS + 1 : 17;

  typedef struct packed {
    logic                 ar;
    logic [TIME_BITS-1:0] el;
    logic [TIME_BITS-1:0] per;
    logic [LW-1:0]        nx;
    logic [LW-1:0]        pv;
  } ent_t;

  ent_t mem [TIMERS];
  ent_t rd;
  logic [TIMERS-1:0] in_use, counting;
  logic [LW-1:0] head, tail, cur;
  logic [LW-1:0] f_nx, f_pv;
  logic [SW-1:0] alloc_slot;
  stp_state_t state, state_next;
  stp_in_t req;
  logic [CW-1:0] nfire;
  logic pend;
  logic [SW-1:0] pend_slot;

  logic          wr_en;
  logic [SW-1:0] wr_addr;
  ent_t          wr_data;
  logic [SW-1:0] rd_addr;
  logic          res_en;
  stp_out_t      res_next;

  logic [SW-1:0] cmd_slot;
  logic [SW-1:0] free_s;
  logic          any_free;
  logic [DW-1:0] sum;
  logic [TIME_BITS-1:0] el_new;
  logic fires;
  logic bad;

  assign cmd_slot = SW'(cmd_in.slot);

  // lowest free slot
  always_comb begin
    free_s = '0;
    any_free = 1'b0;
    for (int i = TIMERS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_s = SW'(i);
        any_free = 1'b1;
      end
    end
  end

  always_comb begin
    sum = DW'(rd.el) + DW'(req.delta);
    el_new = (sum > DW'(TMAX)) ? TMAX : sum[TIME_BITS-1:0];
    fires = counting[cur[SW-1:0]] && (el_new >= rd.per);
  end

  assign bad = (32'(cmd_in.slot) >= TIMERS) || !in_use[cmd_slot];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) begin
        case (cmd_in.cmd)
          CMD_ALLOC: if (any_free && tail != NIL) state_next = ST_ALLOC_WR;
          CMD_FREE: if (!bad) state_next = ST_FREE_RD;
          CMD_TICK: state_next = ST_TICK;
          default: ;
        endcase
      end
      ST_ALLOC_WR: state_next = ST_IDLE;
      ST_FREE_RD: state_next = ST_FREE_NX;
      ST_FREE_NX: state_next = ST_FREE_PV;
      ST_FREE_PV: state_next = ST_IDLE;
      ST_TICK: if (cur == NIL) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  // memory port control and result words
  always_comb begin
    rd_addr = cur[SW-1:0];
    wr_en = 1'b0;
    wr_addr = cur[SW-1:0];
    wr_data = rd;
    res_en = 1'b0;
    res_next = '0;
    unique case (state)
      ST_IDLE: begin
        case (cmd_in.cmd)
          CMD_ALLOC: rd_addr = tail[SW-1:0];
          CMD_FREE: rd_addr = cmd_slot;
          CMD_TICK: rd_addr = head[SW-1:0];
          default: ;
        endcase
        if (start) begin
          case (cmd_in.cmd)
            CMD_ALLOC: begin
              res_en = 1'b1;
              if (any_free) begin
                res_next = '{KIND_ALLOCATED, 4'(free_s), 1'b1};
                wr_en = 1'b1;
                wr_addr = free_s;
                wr_data.ar = cmd_in.repeat_req;
                wr_data.el = TIME_BITS'(cmd_in.start_elapsed);
                wr_data.per = TIME_BITS'(cmd_in.period);
                wr_data.nx = NIL;
                wr_data.pv = tail;
              end else begin
                res_next = '{KIND_FULL, 4'd0, 1'b1};
              end
            end
            CMD_FREE: if (bad) begin
              res_en = 1'b1;
              res_next = '{KIND_BAD, cmd_in.slot, 1'b1};
            end
            default: ;
          endcase
        end
      end
      // old tail entry was read at accept, now point it at the new slot
      ST_ALLOC_WR: begin
        wr_en = 1'b1;
        wr_data.nx = LW'(alloc_slot);
      end
      ST_FREE_RD: rd_addr = rd.nx[SW-1:0];
      ST_FREE_NX: begin
        rd_addr = f_pv[SW-1:0];
        if (f_nx != NIL) begin
          wr_en = 1'b1;
          wr_addr = f_nx[SW-1:0];
          wr_data.pv = f_pv;
        end
      end
      ST_FREE_PV: begin
        res_en = 1'b1;
        res_next = '{KIND_FREED, req.slot, 1'b1};
        if (f_pv != NIL) begin
          wr_en = 1'b1;
          wr_addr = f_pv[SW-1:0];
          wr_data.nx = f_nx;
        end
      end
      // entry of cur is in rd; the next one is read while this one is written
      ST_TICK: begin
        rd_addr = rd.nx[SW-1:0];
        if (cur == NIL) begin
          res_en = pend;
          res_next = '{KIND_FIRED, 4'(pend_slot), 1'b1};
        end else begin
          if (counting[cur[SW-1:0]]) begin
            wr_en = 1'b1;
            wr_data.el = (fires && rd.ar) ? '0 : el_new;
          end
          if (fires && 32'(nfire) < MAX_RESULTS && pend) begin
            res_en = 1'b1;
            res_next = '{KIND_FIRED, 4'(pend_slot), 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_en;
    end
    if (res_en) result <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      in_use <= '0;
      counting <= '0;
      head <= NIL;
      tail <= NIL;
      cur <= NIL;
      nfire <= '0;
      pend <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: if (start) begin
          req <= cmd_in;
          case (cmd_in.cmd)
            CMD_ALLOC: if (any_free) begin
              in_use[free_s] <= 1'b1;
              counting[free_s] <= cmd_in.start_active;
              alloc_slot <= free_s;
              cur <= tail;
              tail <= LW'(free_s);
              if (tail == NIL) head <= LW'(free_s);
            end
            CMD_FREE: if (!bad) cur <= LW'(cmd_in.slot);
            CMD_TICK: begin
              cur <= head;
              nfire <= '0;
              pend <= 1'b0;
            end
            default: ;
          endcase
        end
        ST_FREE_RD: begin
          f_nx <= rd.nx;
          f_pv <= rd.pv;
          if (rd.nx == NIL) tail <= rd.pv;
          if (rd.pv == NIL) head <= rd.nx;
          in_use[cur[SW-1:0]] <= 1'b0;
          counting[cur[SW-1:0]] <= 1'b0;
        end
        ST_TICK: if (cur != NIL) begin
          // past the limit the last reported fire stays pending for the list end
          if (fires && 32'(nfire) < MAX_RESULTS) begin
            pend <= 1'b1;
            pend_slot <= cur[SW-1:0];
            nfire <= nfire + CW'(1);
          end
          cur <= rd.nx;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> result.kind <= KIND_FIRED)
    else $error("bad result kind");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start && cmd_in.cmd == CMD_ALLOC) |=> done)
    else $error("allocate gave no result");
  assert property (@(posedge clk) disable iff (rst) (head == NIL) |-> (tail == NIL))
    else $error("list ends disagree");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_TICK && cur != NIL) |-> in_use[cur[SW-1:0]])
    else $error("listed timer not in use");
endmodule
